// ===== rtl/core/euler_to_quaternion_unit_defines.svh =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit_defines.svh
// Assertion macros shared by the checkers of the Euler-to-quaternion unit.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_UNIT_DEFINES_SVH
`define EULER_TO_QUATERNION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define E2Q_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define E2Q_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and the arctangent table of the Euler-to-quaternion
// unit.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // Default build parameters
  localparam int unsigned DEF_CORDIC_STEPS = 16;
  localparam int unsigned DEF_ANGLE_BITS   = 16;

  // Field widths
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned Q15_W  = 16;

  // CORDIC datapath: x, y in Q2.30 with guard bits
  localparam int unsigned XY_W   = 34;
  // Cosine and sine in Q.20
  localparam int unsigned TRIG_W = 24;
  localparam int unsigned TRIG_SHIFT = 10;
  // Products
  localparam int unsigned PAIR_W = 2 * TRIG_W;
  localparam int unsigned HALF_W = PAIR_W / 2;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned Q15_SHIFT = 45;

  localparam logic signed [XY_W-1:0]  GAIN_Q30 = 34'sd652032874;
  localparam logic signed [Q15_W-1:0] Q15_MAX  = 16'sh7FFF;
  localparam logic signed [Q15_W-1:0] Q15_MIN  = 16'sh8000;

  // Arctangent of 2^-i, one turn = 2^32
  localparam int unsigned ATAN_LEN = 24;
  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Arctangent step rounded half up to an accumulator of 2^(ab+1) per turn
  function automatic logic [32:0] atan_step(input int unsigned idx, input int unsigned ab);
    int unsigned ts;
    logic [32:0] v;
    ts = 31 - ab;
    v  = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (ts - 1));
    return v >> ts;
  endfunction

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [Q15_W-1:0] z;
    logic signed [Q15_W-1:0] y;
    logic signed [Q15_W-1:0] x;
    logic signed [Q15_W-1:0] w;
  } quat_t;

endpackage

// ===== rtl/core/euler_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Roll, pitch and yaw binary angles in, unit quaternion in Q1.15 out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one angle triple per word; master stream carries
//   one quaternion per word. A word moves when tvalid and tready are high.
//   Three CORDIC lanes (roll, pitch, yaw) run side by side, one iteration
//   per stage, followed by a four-stage product and rounding tree.
//   Path: CORDIC stages, rounding register, the four merge stages, then
//   the output register that drives m_axis_tvalid and m_axis_tdata.
//   Throughput: one word per cycle while the output side keeps up.
//   Stall: while a result waits at the output, the pipeline keeps
//   advancing until the next word reaches its end and moves into the skid
//   register; then the whole pipeline holds and s_axis_tready drops until
//   the receiver takes a word.
//   Reset: all valid bits clear, nothing in flight, s_axis_tready high.
//   The block keeps no state between words.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit #(
  parameter int unsigned CORDIC_STEPS = e2q_pkg::DEF_CORDIC_STEPS,
  parameter int unsigned ANGLE_BITS   = e2q_pkg::DEF_ANGLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  // Lanes plus rounding register, then four merge stages
  localparam int unsigned VLAT = CORDIC_STEPS + 5;

  logic            en;
  logic [VLAT-1:0] valid_q, valid_d;
  trig_t           roll_trig, pitch_trig, yaw_trig;
  quat_t           quat;
  quat_t           out_q, skid_q;
  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic            last_valid;

  // Pipeline advances whenever the skid register is free
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  e2q_cordic_lane #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_roll (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(signed'(s_axis_tdata[15:0])),
    .trig_o (roll_trig)
  );

  e2q_cordic_lane #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_pitch (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(signed'(s_axis_tdata[31:16])),
    .trig_o (pitch_trig)
  );

  e2q_cordic_lane #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_yaw (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(signed'(s_axis_tdata[47:32])),
    .trig_o (yaw_trig)
  );

  e2q_quat_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .roll_i (roll_trig),
    .pitch_i(pitch_trig),
    .yaw_i  (yaw_trig),
    .quat_o (quat)
  );

  // Track which pipeline stages hold a word
  always_comb begin
    valid_d = valid_q;
    if (en) begin
      valid_d = {valid_q[VLAT-2:0], s_axis_tvalid};
    end
  end

  assign last_valid = valid_q[VLAT-1];

  // Output register and skid register control
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (en && last_valid) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_d = 1'b1;
      end else begin
        skid_valid_d = 1'b1;
      end
    end else if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Load output and skid payloads
  always_ff @(posedge clk_i) begin
    if (en && last_valid) begin
      if (!out_valid_q || m_axis_tready) begin
        out_q <= quat;
      end else begin
        skid_q <= quat;
      end
    end else if (out_valid_q && m_axis_tready && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/core/e2q_cordic_lane.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic_lane
// Pipelined rotation-mode CORDIC: cosine and sine of half a binary angle,
// one iteration per stage, results rounded to Q.20.
// ----------------------------------------------------------------------------
module e2q_cordic_lane #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ANGLE_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [e2q_pkg::ANG_W-1:0]   angle_i,
  output e2q_pkg::trig_t                     trig_o
);
  import e2q_pkg::*;

  localparam int unsigned ZW = ANGLE_BITS + 2;

  logic signed [XY_W-1:0] x_q [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0]   z_q [CORDIC_STEPS];
  logic signed [ZW-1:0]   z_init;
  logic signed [XY_W-1:0] cos_full, sin_full;
  trig_t                  trig_q;

  // Scale the input angle to the half-angle accumulator
  if (ANGLE_BITS >= ANG_W) begin : g_up
    assign z_init = ZW'(angle_i) <<< (ANGLE_BITS - ANG_W);
  end else begin : g_down
    assign z_init = ZW'(angle_i >>> (ANG_W - ANGLE_BITS));
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(i, ANGLE_BITS));
    logic signed [XY_W-1:0] x_in, y_in;
    logic signed [ZW-1:0]   z_in;

    if (i == 0) begin : g_first
      assign x_in = GAIN_Q30;
      assign y_in = '0;
      assign z_in = z_init;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[ZW-1]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - STEP;
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + STEP;
        end
      end
    end
  end

  // Round x, y half up to Q.20
  assign cos_full = (x_q[CORDIC_STEPS-1] + XY_W'(512)) >>> TRIG_SHIFT;
  assign sin_full = (y_q[CORDIC_STEPS-1] + XY_W'(512)) >>> TRIG_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.c <= cos_full[TRIG_W-1:0];
      trig_q.s <= sin_full[TRIG_W-1:0];
    end
  end

  assign trig_o = trig_q;

endmodule

// ===== rtl/core/e2q_quat_merge.sv =====
// ----------------------------------------------------------------------------
// e2q_quat_merge
// Combines the three lanes' half-angle cosines and sines into w, x, y, z:
// pair products, split partial products, recombine, sum, round to Q1.15.
// ----------------------------------------------------------------------------
module e2q_quat_merge (
  input  logic           clk_i,
  input  logic           en_i,
  input  e2q_pkg::trig_t roll_i,
  input  e2q_pkg::trig_t pitch_i,
  input  e2q_pkg::trig_t yaw_i,
  output e2q_pkg::quat_t quat_o
);
  import e2q_pkg::*;

  localparam int unsigned HI_W = TRIG_W + HALF_W;
  localparam int unsigned LO_W = TRIG_W + HALF_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(64'sd1 <<< (Q15_SHIFT - 1));

  // Stage A: pitch/yaw pair products, roll delayed alongside
  logic signed [TRIG_W-1:0] cr_q, sr_q;
  logic signed [PAIR_W-1:0] pair_q [4];   // cpcy, spsy, cpsy, spcy

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q      <= roll_i.c;
      sr_q      <= roll_i.s;
      pair_q[0] <= pitch_i.c * yaw_i.c;
      pair_q[1] <= pitch_i.s * yaw_i.s;
      pair_q[2] <= pitch_i.c * yaw_i.s;
      pair_q[3] <= pitch_i.s * yaw_i.c;
    end
  end

  // Select roll term and pair product for each of the eight products
  logic signed [TRIG_W-1:0] a_sel [8];
  logic signed [PAIR_W-1:0] p_sel [8];

  always_comb begin
    a_sel[0] = cr_q; p_sel[0] = pair_q[0];
    a_sel[1] = sr_q; p_sel[1] = pair_q[1];
    a_sel[2] = sr_q; p_sel[2] = pair_q[0];
    a_sel[3] = cr_q; p_sel[3] = pair_q[1];
    a_sel[4] = cr_q; p_sel[4] = pair_q[3];
    a_sel[5] = sr_q; p_sel[5] = pair_q[2];
    a_sel[6] = cr_q; p_sel[6] = pair_q[2];
    a_sel[7] = sr_q; p_sel[7] = pair_q[3];
  end

  logic signed [HI_W-1:0]   hi_q   [8];
  logic signed [LO_W-1:0]   lo_q   [8];
  logic signed [PROD_W-1:0] prod_q [8];
  logic signed [PROD_W-1:0] sum_q  [4];
  logic signed [Q15_W-1:0]  q      [4];

  for (genvar k = 0; k < 8; k++) begin : g_prod
    // Stage B: split the pair product into a signed high and unsigned low half
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hi_q[k] <= a_sel[k] * signed'(p_sel[k][PAIR_W-1:HALF_W]);
        lo_q[k] <= a_sel[k] * signed'({1'b0, p_sel[k][HALF_W-1:0]});
      end
    end

    // Stage C: recombine the halves
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[k] <= (PROD_W'(hi_q[k]) <<< HALF_W) + PROD_W'(lo_q[k]);
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_sum
    localparam bit SUB = (j % 2) == 1;
    logic signed [PROD_W-1:0] rnd;

    // Stage D: add or subtract the two products of each component
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (SUB) begin
          sum_q[j] <= prod_q[2*j] - prod_q[2*j+1];
        end else begin
          sum_q[j] <= prod_q[2*j] + prod_q[2*j+1];
        end
      end
    end

    // Round half up to Q1.15 and saturate
    always_comb begin
      rnd = (sum_q[j] + ROUND_ADD) >>> Q15_SHIFT;
      if (rnd > PROD_W'(Q15_MAX)) begin
        q[j] = Q15_MAX;
      end else if (rnd < PROD_W'(Q15_MIN)) begin
        q[j] = Q15_MIN;
      end else begin
        q[j] = rnd[Q15_W-1:0];
      end
    end
  end

  assign quat_o.w = q[0];
  assign quat_o.x = q[1];
  assign quat_o.y = q[2];
  assign quat_o.z = q[3];

endmodule

// ===== rtl/core/e2q_checker.sv =====
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks of the Euler-to-quaternion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_unit_defines.svh"

module e2q_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_i
);

  // Hold a stalled result word
  `E2Q_ASSERT_NEXT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i, "result word dropped while stalled")
  `E2Q_ASSERT_NEXT(a_out_stable, m_axis_tvalid_i && !m_axis_tready_i, $stable(m_axis_tdata_i), "stalled result word changed")

  // Input side blocks only when a result is waiting at the output
  `E2Q_ASSERT_NOW(a_block_has_out, !s_axis_tready_i, m_axis_tvalid_i, "input blocked with no result pending")

  // Input side stays blocked until the receiver takes a word
  `E2Q_ASSERT_NEXT(a_block_holds, !s_axis_tready_i && !m_axis_tready_i, !s_axis_tready_i, "input unblocked without output progress")

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_i(s_axis_tready),
  .m_axis_tvalid_i(m_axis_tvalid),
  .m_axis_tready_i(m_axis_tready),
  .m_axis_tdata_i (m_axis_tdata)
);

// ===== tb/sv/euler_to_quaternion_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit_tb
// Drives angle triples into the slave stream and checks every quaternion on
// the master stream against a bit-exact CORDIC and product model kept here.
// Starts with corner angles, then runs random triples. Both stream sides
// idle at random. One long receiver hold fills the pipeline, and one sender
// pause amid the random blocks lets all results drain.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit_tb;

  localparam int STEPS         = 16;
  localparam int ABITS         = 16;
  localparam int HALF_SHIFT    = ABITS - 16;
  localparam int TABLE_SHIFT   = 31 - ABITS;
  localparam int ATAN_ENTRIES  = 24;
  localparam int LATENCY       = STEPS + 6;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BLOCKS        = 8;
  localparam int BLOCK_ITEMS   = 50;

  // Gain-compensated CORDIC start value, Q2.30
  localparam longint START_X = 64'sd652032874;

  // Arctangent of 2^-i, one turn = 2^32
  localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [e2q_pkg::ANG_W-1:0] angle_t;

  // Slave word layout, roll in the low bits
  typedef struct packed {
    angle_t yaw;
    angle_t pitch;
    angle_t roll;
  } euler_t;

  // Expected quaternions in arrival order, with their predictor
  class quat_scoreboard;
    e2q_pkg::quat_t expected_quats[$];
    int noted;
    int checked;
    int mismatches;

    function new();
      noted      = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    // Cosine and sine of half the angle, Q.20
    function void half_trig(input angle_t ang, output longint c, output longint s);
      longint x, y, z, dx, dy, step;
      x = START_X;
      y = 0;
      if (HALF_SHIFT >= 0) begin
        z = longint'(ang) <<< HALF_SHIFT;
      end else begin
        z = longint'(ang) >>> (-HALF_SHIFT);
      end
      for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
        step = (longint'(ATAN_TURN[i]) + (longint'(1) <<< (TABLE_SHIFT - 1))) >>> TABLE_SHIFT;
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - step;
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + step;
        end
      end
      c = (x + 512) >>> 10;
      s = (y + 512) >>> 10;
    endfunction

    // Round a Q.60 sum half up to Q1.15 and saturate
    function logic signed [e2q_pkg::Q15_W-1:0] round_to_q15(input longint p);
      longint r;
      r = (p + (longint'(1) <<< 44)) >>> 45;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[e2q_pkg::Q15_W-1:0];
    endfunction

    function e2q_pkg::quat_t predict_quat(input euler_t a);
      longint cr, sr, cp, sp, cy, sy;
      longint cpcy, spsy, cpsy, spcy;
      e2q_pkg::quat_t q;
      half_trig(a.roll, cr, sr);
      half_trig(a.pitch, cp, sp);
      half_trig(a.yaw, cy, sy);
      cpcy = cp * cy;
      spsy = sp * sy;
      cpsy = cp * sy;
      spcy = sp * cy;
      q.w = round_to_q15(cr * cpcy + sr * spsy);
      q.x = round_to_q15(sr * cpcy - cr * spsy);
      q.y = round_to_q15(cr * spcy + sr * cpsy);
      q.z = round_to_q15(cr * cpsy - sr * spcy);
      return q;
    endfunction

    function void note_angles(input euler_t a);
      expected_quats.push_back(predict_quat(a));
      noted++;
    endfunction

    function void check_quat(input e2q_pkg::quat_t got);
      e2q_pkg::quat_t exp_q;
      checked++;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d", got.w, got.x, got.y, got.z);
        return;
      end
      exp_q = expected_quats.pop_front();
      if (exp_q != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("quaternion mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                   exp_q.w, exp_q.x, exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
      end
    endfunction

    function int pending();
      return expected_quats.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // roll_angle, pitch_angle, yaw_angle
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // quat_w, quat_x, quat_y, quat_z

  quat_scoreboard quats;
  int  cycle_count;
  int  input_stalls;
  bit  tx_calm;
  bit  rx_calm;
  bit  rx_hold_req;

  euler_to_quaternion_unit #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Idle length: mostly a few cycles, now and then a long stretch
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random angle, biased toward the wrap point, zero and the quarter turns
  function automatic angle_t rand_angle();
    angle_t base;
    if ($urandom_range(0, 9) < 7) return angle_t'($urandom);
    case ($urandom_range(0, 4))
      0: base = 16'sh8000;
      1: base = 16'sh7FFF;
      2: base = 16'sh0000;
      3: base = 16'sh4000;
      default: base = 16'shC000;
    endcase
    return base + angle_t'($urandom_range(0, 2)) - 16'sd1;
  endfunction

  // Offer one angle triple and hold it until the block takes the word
  task automatic send_angles(input angle_t roll, input angle_t pitch, input angle_t yaw);
    euler_t a;
    int gap;
    a.roll  = roll;
    a.pitch = pitch;
    a.yaw   = yaw;
    gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= a;
    do @(posedge clk_i); while (!s_axis_tready);
    quats.note_angles(a);
  endtask

  // Drop valid and wait until every expected quaternion has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (quats.pending() != 0);
  endtask

  // Check each quaternion the receiver takes; count input stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) quats.check_quat(m_axis_tdata);
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
  end

  // Give up on a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d quaternions outstanding",
                 cycle_count, quats.pending());
        $display("euler_to_quaternion_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver: alternate ready runs and stalls, or hold off on request
  initial begin : rx_side
    int run_left;
    int hold_left;
    bit ready_now;
    run_left  = 0;
    hold_left = 0;
    ready_now = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_now = 1'b0;
        run_left  = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (rx_calm || !ready_now) begin
        ready_now = 1'b1;
        run_left  = $urandom_range(1, 24);
      end else begin
        ready_now = 1'b0;
        run_left  = idle_len() - 1;
      end
      m_axis_tready <= ready_now;
    end
  end

  // Stimulus: corner triples, then random blocks with varied idling
  initial begin : stimulus
    int blk;
    int k;
    quats        = new();
    input_stalls = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    rx_hold_req  = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero angles give +1 for w, which must saturate
    send_angles(16'sh0000, 16'sh0000, 16'sh0000);
    // Minus pi on one axis drives a component to -1
    send_angles(16'sh8000, 16'sh0000, 16'sh0000);
    send_angles(16'sh0000, 16'sh8000, 16'sh0000);
    send_angles(16'sh0000, 16'sh0000, 16'sh8000);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_angles(16'sh7FFF, 16'sh8000, 16'sh0000);
    send_angles(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_angles(16'sh4000, 16'sh0000, 16'sh0000);
    send_angles(16'sh0000, 16'sh4000, 16'sh0000);
    send_angles(16'sh0000, 16'sh0000, 16'sh4000);
    send_angles(16'shC000, 16'shC000, 16'shC000);
    send_angles(16'sh4000, 16'sh4000, 16'sh4000);
    send_angles(16'sh0001, 16'shFFFF, 16'sh0001);
    send_angles(16'shFFFF, 16'sh0001, 16'shFFFF);
    send_angles(16'sh5555, 16'shAAAA, 16'sh2AAA);
    wait_drained();

    for (blk = 0; blk < BLOCKS; blk++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (blk == 2) begin
        // Back-to-back words against a stalled receiver fill the pipeline
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
      end
      if (blk == 5) wait_drained();
      for (k = 0; k < BLOCK_ITEMS; k++)
        send_angles(rand_angle(), rand_angle(), rand_angle());
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("sent %0d angle triples, checked %0d quaternions, %0d input stall cycles",
             quats.noted, quats.checked, input_stalls);
    if (quats.mismatches == 0 && quats.pending() == 0) begin
      $display("euler_to_quaternion_unit_tb OK");
    end else begin
      $display("%0d mismatches, %0d outstanding", quats.mismatches, quats.pending());
      $display("euler_to_quaternion_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic_lane.sv
rtl/core/e2q_quat_merge.sv
rtl/core/euler_to_quaternion_unit.sv
rtl/core/e2q_checker.sv
tb/sv/euler_to_quaternion_unit_tb.sv
